@@ design/ghal_pkg.sv @@
// ----------------------------------------------------------------------------
// ghal_pkg
// Types and constants shared by the generational handle allocator.
// ----------------------------------------------------------------------------
package ghal_pkg;

	localparam int CAPACITY = 1024;
	localparam int GEN_BITS = 12;

	localparam int IDX_W  = 10;
	localparam int GEN_W  = GEN_BITS;
	localparam int SGEN_W = GEN_BITS + 1;
	localparam int CNT_W  = 11;
	localparam int NODE_W = 32;
	localparam int TAG_W  = 16;
	localparam int KIND_W = 3;

	localparam int S_DATA_W = 72;
	localparam int M_DATA_W = 104;

	localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD       = 3'd0,
		KIND_REMOVE    = 3'd1,
		KIND_QUERY     = 3'd2,
		KIND_MARK      = 3'd3,
		KIND_DONE      = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_INVALID   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NULL_NODE = 2'd3
	} status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

@@ design/ghal_ram.sv @@
// ----------------------------------------------------------------------------
// ghal_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ghal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data until the next read is issued
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/generational_handle_allocator.sv @@
// An accepted beat is captured, then written to the output register when the
// execute state commits; a new item is taken only in the idle state. Each item
// reads the slot memories when accepted and writes them back in execute.
// An unconsumed result holds the execute state, and the input waits with it.
// Reset: counters, free-list pointers and dirty flags clear, owner_tag goes
// to 1; the slot memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// generational_handle_allocator
// Slot allocator with generation-checked handles and a FIFO free list.
// ----------------------------------------------------------------------------
module generational_handle_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ghal_pkg::TAG_W-1:0]        cfg_wdata,   // owner_tag
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// owner_node[31:0], slot_index[41:32], slot_generation[53:42],
	// handle_tag[69:54], check_tag[70], zero[71]
	input  logic [ghal_pkg::S_DATA_W-1:0]     s_tdata,
	input  logic [ghal_pkg::KIND_W-1:0]       s_tuser,     // kind[2:0]
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// status[1:0], handle_valid[2], out_index[12:3], out_generation[24:13],
	// out_tag[40:25], out_node[72:41], used_slots[83:73],
	// slots_allocated[94:84], needs_update[95], needs_assignment_update[96],
	// zero[103:97]
	output logic [ghal_pkg::M_DATA_W-1:0]     m_tdata
);
	import ghal_pkg::*;

	state_t state_q, state_d;

	logic [TAG_W-1:0]  owner_tag_q;
	logic [IDX_W-1:0]  free_head_q, free_tail_q;
	logic              free_empty_q;
	logic [CNT_W-1:0]  alloc_q, used_q;
	logic [1:0]        dirty_q;

	logic [KIND_W-1:0] kind_s1;
	logic [NODE_W-1:0] node_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [GEN_W-1:0]  gen_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              chk_s1;

	logic              out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;

	logic              accept, commit;

	// memory ports
	logic              gen_we, node_we, next_we;
	logic [IDX_W-1:0]  gen_waddr, node_waddr, next_waddr;
	logic [SGEN_W-1:0] gen_wdata, gen_rd;
	logic [NODE_W-1:0] node_wdata, node_rd;
	logic [IDX_W-1:0]  next_wdata, next_rd;
	logic [IDX_W-1:0]  gen_raddr;

	// step results
	logic [IDX_W-1:0]  head_d, tail_d;
	logic              empty_d;
	logic [CNT_W-1:0]  alloc_d, used_d;
	logic [1:0]        dirty_d;
	status_t           res_status;
	logic              res_valid;
	logic [IDX_W-1:0]  res_idx;
	logic [GEN_W-1:0]  res_gen;
	logic [TAG_W-1:0]  res_tag;
	logic [NODE_W-1:0] res_node;
	logic              live;
	logic [SGEN_W-1:0] gen_inc;

	// ------------------------------------------------------------------
	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		commit   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	// ------------------------------------------------------------------
	// capture the beat
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= s_tuser;
			node_s1 <= s_tdata[31:0];
			idx_s1  <= s_tdata[41:32];
			gen_s1  <= s_tdata[53:42];
			tag_s1  <= s_tdata[69:54];
			chk_s1  <= s_tdata[70];
		end
	end

	// add reads the generation of the free-list head, others the given slot
	assign gen_raddr = (kind_t'(s_tuser) == KIND_ADD) ? free_head_q : s_tdata[41:32];

	ghal_ram #(.WIDTH(SGEN_W), .DEPTH(CAPACITY)) u_gen_ram (
		.clk   (clk),
		.we    (gen_we),
		.waddr (gen_waddr),
		.wdata (gen_wdata),
		.re    (accept),
		.raddr (gen_raddr),
		.rdata (gen_rd)
	);

	ghal_ram #(.WIDTH(NODE_W), .DEPTH(CAPACITY)) u_node_ram (
		.clk   (clk),
		.we    (node_we),
		.waddr (node_waddr),
		.wdata (node_wdata),
		.re    (accept),
		.raddr (s_tdata[41:32]),
		.rdata (node_rd)
	);

	ghal_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.waddr (next_waddr),
		.wdata (next_wdata),
		.re    (accept),
		.raddr (free_head_q),
		.rdata (next_rd)
	);

	// ------------------------------------------------------------------
	// execute: check, modify, write back
	assign live = (!chk_s1 || (tag_s1 == owner_tag_q))
		&& ({1'b0, idx_s1} < alloc_q)
		&& ({1'b0, gen_s1} == gen_rd);
	assign gen_inc = gen_rd + SGEN_W'(1);

	always_comb begin
		head_d     = free_head_q;
		tail_d     = free_tail_q;
		empty_d    = free_empty_q;
		alloc_d    = alloc_q;
		used_d     = used_q;
		dirty_d    = dirty_q;
		res_status = STAT_OK;
		res_valid  = 1'b0;
		res_idx    = '0;
		res_gen    = '0;
		res_tag    = '0;
		res_node   = '0;
		gen_we     = 1'b0;
		gen_waddr  = idx_s1;
		gen_wdata  = gen_inc;
		node_we    = 1'b0;
		node_waddr = idx_s1;
		node_wdata = '0;
		next_we    = 1'b0;
		next_waddr = free_tail_q;
		next_wdata = idx_s1;
		case (kind_t'(kind_s1))
			KIND_ADD: begin
				if (node_s1 == '0) begin
					res_status = STAT_NULL_NODE;
				end else if (!free_empty_q) begin
					// reuse the oldest free slot
					if (free_head_q == free_tail_q) begin
						empty_d = 1'b1;
					end else begin
						head_d = next_rd;
					end
					node_we    = 1'b1;
					node_waddr = free_head_q;
					node_wdata = node_s1;
					used_d     = used_q + CNT_W'(1);
					dirty_d    = 2'b11;
					res_valid  = 1'b1;
					res_idx    = free_head_q;
					res_gen    = gen_rd[GEN_W-1:0];
					res_tag    = owner_tag_q;
				end else if (alloc_q != CAP_COUNT) begin
					// create a fresh slot at generation one
					gen_we     = 1'b1;
					gen_waddr  = alloc_q[IDX_W-1:0];
					gen_wdata  = SGEN_W'(1);
					node_we    = 1'b1;
					node_waddr = alloc_q[IDX_W-1:0];
					node_wdata = node_s1;
					alloc_d    = alloc_q + CNT_W'(1);
					used_d     = used_q + CNT_W'(1);
					dirty_d    = 2'b11;
					res_valid  = 1'b1;
					res_idx    = alloc_q[IDX_W-1:0];
					res_gen    = GEN_W'(1);
					res_tag    = owner_tag_q;
				end else begin
					res_status = STAT_FULL;
				end
			end
			KIND_REMOVE: begin
				if (!live) begin
					res_status = STAT_INVALID;
				end else begin
					res_valid = 1'b1;
					dirty_d   = 2'b11;
					gen_we    = 1'b1;
					node_we   = 1'b1;
					// a slot whose generation wraps out of range is retired
					if (!gen_inc[SGEN_W-1]) begin
						if (free_empty_q) begin
							head_d  = idx_s1;
							empty_d = 1'b0;
						end else begin
							next_we = 1'b1;
						end
						tail_d = idx_s1;
						used_d = used_q - CNT_W'(1);
					end
				end
			end
			KIND_QUERY: begin
				if (live) begin
					res_valid = 1'b1;
					res_node  = node_rd;
				end else begin
					res_status = STAT_INVALID;
				end
			end
			KIND_MARK: dirty_d = dirty_q | 2'b01;
			KIND_DONE: dirty_d = 2'b00;
			default: ;
		endcase
		if (!commit) begin
			gen_we  = 1'b0;
			node_we = 1'b0;
			next_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owner_tag_q  <= TAG_W'(1);
			free_head_q  <= '0;
			free_tail_q  <= '0;
			free_empty_q <= 1'b1;
			alloc_q      <= '0;
			used_q       <= '0;
			dirty_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				owner_tag_q <= cfg_wdata;
			end
			if (commit) begin
				free_head_q  <= head_d;
				free_tail_q  <= tail_d;
				free_empty_q <= empty_d;
				alloc_q      <= alloc_d;
				used_q       <= used_d;
				dirty_q      <= dirty_d;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= {7'd0, dirty_d[1], dirty_d[0], alloc_d, used_d, res_node,
				res_tag, res_gen, res_idx, res_valid, res_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ------------------------------------------------------------------
	// checks
	a_used_le_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= alloc_q)
		else $error("used count exceeds allocated count");

	a_list_needs_slots: assert property (@(posedge clk) disable iff (!arst_n)
		!free_empty_q |-> (alloc_q != '0) && ({1'b0, free_head_q} < alloc_q)
			&& ({1'b0, free_tail_q} < alloc_q))
		else $error("free list points beyond created slots");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted beat did not enter execute");

	a_full_only_at_cap: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (res_status == STAT_FULL) |-> (alloc_q == CAP_COUNT) && free_empty_q)
		else $error("table full reported with capacity left");

	a_commit_frees_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |-> !out_valid_q || m_tready)
		else $error("result overwrote a pending output beat");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for generational_handle_allocator. A shadow copy of
// the slot table, free list, counters and dirty flags predicts every result
// beat, and each result beat is checked field by field. A directed run
// covers handle checks and FIFO reuse. Random traffic then follows under
// several owner tags, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb;
	import ghal_pkg::*;

	localparam int IDLE_LIMIT    = 4000;
	localparam int RANDOM_PHASES = 4;
	localparam int PHASE_ITEMS   = 175;
	localparam int BURST_ITEMS   = 40;

	localparam logic [SGEN_W-1:0] GEN_RETIRED    = SGEN_W'(1 << GEN_BITS);
	localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
	localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] node;
		logic [IDX_W-1:0]  index;
		logic [GEN_W-1:0]  generation;
		logic [TAG_W-1:0]  tag;
		logic              check;
	} request_t;

	typedef struct packed {
		status_t           status;
		logic              valid;
		logic [IDX_W-1:0]  index;
		logic [GEN_W-1:0]  generation;
		logic [TAG_W-1:0]  tag;
		logic [NODE_W-1:0] node;
		logic [CNT_W-1:0]  used;
		logic [CNT_W-1:0]  allocated;
		logic              dirty_layout;
		logic              dirty_assign;
	} outcome_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [TAG_W-1:0]    cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [KIND_W-1:0]   s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;

	generational_handle_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// shadow of the allocator
	logic [SGEN_W-1:0] gen_of  [CAPACITY];
	logic [NODE_W-1:0] node_of [CAPACITY];
	logic [IDX_W-1:0]  next_of [CAPACITY];
	logic [IDX_W-1:0]  fl_head;
	logic [IDX_W-1:0]  fl_tail;
	logic              fl_empty;
	logic [CNT_W-1:0]  created;
	logic [CNT_W-1:0]  busy;
	logic [1:0]        dirty;
	logic [TAG_W-1:0]  tag_reg;

	// slots currently handed out, for picking live handles
	logic [IDX_W-1:0]  held_list [CAPACITY];
	int                held_pos  [CAPACITY];
	bit                held      [CAPACITY];
	int                held_total;

	outcome_t pending_outcomes [$];
	int       errors;
	int       idle_cycles;
	int       stall_left;
	bit       sender_gaps;
	bit       receiver_stalls;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [NODE_W-1:0] nonzero_node();
		logic [NODE_W-1:0] n;
		n = $urandom();
		if (n == '0)
			n = NODE_W'(1);
		return n;
	endfunction

	function automatic request_t make_op(logic [KIND_W-1:0] kind, logic [NODE_W-1:0] node,
			logic [IDX_W-1:0] index, logic [GEN_W-1:0] generation,
			logic [TAG_W-1:0] tag, logic check);
		request_t r;
		r.kind       = kind;
		r.node       = node;
		r.index      = index;
		r.generation = generation;
		r.tag        = tag;
		r.check      = check;
		return r;
	endfunction

	function automatic void held_add(logic [IDX_W-1:0] idx);
		held_list[held_total] = idx;
		held_pos[idx]         = held_total;
		held[idx]             = 1'b1;
		held_total++;
	endfunction

	function automatic void held_drop(logic [IDX_W-1:0] idx);
		int p;
		p = held_pos[idx];
		held_total--;
		held_list[p]           = held_list[held_total];
		held_pos[held_list[p]] = p;
		held[idx]              = 1'b0;
	endfunction

	function automatic bit handle_is_live(request_t r);
		if (r.check && r.tag != tag_reg)
			return 1'b0;
		if (CNT_W'(r.index) >= created)
			return 1'b0;
		return {1'b0, r.generation} == gen_of[r.index];
	endfunction

	function automatic outcome_t predict_outcome(request_t r);
		outcome_t         o;
		logic [IDX_W-1:0] s;
		o        = '0;
		o.status = STAT_OK;
		case (r.kind)
			KIND_ADD: begin
				if (r.node == '0) begin
					o.status = STAT_NULL_NODE;
				end else if (!fl_empty || created < CAP_COUNT) begin
					if (!fl_empty) begin
						s = fl_head;
						if (fl_head == fl_tail)
							fl_empty = 1'b1;
						else
							fl_head = next_of[s];
					end else begin
						s         = created[IDX_W-1:0];
						gen_of[s] = SGEN_W'(1);
						created   = created + 1'b1;
					end
					node_of[s]   = r.node;
					busy         = busy + 1'b1;
					dirty        = 2'b11;
					o.valid      = 1'b1;
					o.index      = s;
					o.generation = gen_of[s][GEN_W-1:0];
					o.tag        = tag_reg;
				end else begin
					o.status = STAT_FULL;
				end
			end
			KIND_REMOVE: begin
				if (!handle_is_live(r)) begin
					o.status = STAT_INVALID;
				end else begin
					o.valid            = 1'b1;
					dirty              = 2'b11;
					gen_of[r.index]    = gen_of[r.index] + 1'b1;
					node_of[r.index]   = '0;
					// a slot at the generation limit stays out of the free list
					if (gen_of[r.index] != GEN_RETIRED) begin
						next_of[r.index] = '0;
						if (fl_empty) begin
							fl_head  = r.index;
							fl_empty = 1'b0;
						end else begin
							next_of[fl_tail] = r.index;
						end
						fl_tail = r.index;
						busy    = busy - 1'b1;
					end
				end
			end
			KIND_QUERY: begin
				if (handle_is_live(r)) begin
					o.valid = 1'b1;
					o.node  = node_of[r.index];
				end else begin
					o.status = STAT_INVALID;
				end
			end
			KIND_MARK: dirty[0] = 1'b1;
			KIND_DONE: dirty    = 2'b00;
			default: ;
		endcase
		o.used         = busy;
		o.allocated    = created;
		o.dirty_layout = dirty[0];
		o.dirty_assign = dirty[1];
		return o;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_op(input request_t r);
		int       gap;
		outcome_t o;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, r.check, r.tag, r.generation, r.index, r.node};
		s_tuser  <= r.kind;
		do
			@(posedge clk);
		while (!s_tready);
		o = predict_outcome(r);
		pending_outcomes.push_back(o);
		if (o.valid && r.kind == KIND_ADD)
			held_add(o.index);
		if (o.valid && r.kind == KIND_REMOVE)
			held_drop(r.index);
		@(negedge clk);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_owner_tag(input logic [TAG_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		tag_reg    = value;
	endtask

	function automatic request_t random_op();
		request_t r;
		int       roll;
		int       pick;
		int       add_w;
		int       rem_w;
		r.node       = $urandom();
		r.index      = IDX_W'($urandom());
		r.generation = GEN_W'($urandom());
		r.tag        = TAG_W'($urandom());
		r.check      = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 19) == 0)
			r.node = '0;
		// lean towards remove while the table is crowded
		add_w = (held_total > 512) ? 15 : 30;
		rem_w = (held_total > 512) ? 45 : 30;
		roll  = $urandom_range(0, 99);
		if (roll < add_w)
			r.kind = KIND_ADD;
		else if (roll < add_w + rem_w)
			r.kind = KIND_REMOVE;
		else if (roll < 85)
			r.kind = KIND_QUERY;
		else if (roll < 91)
			r.kind = KIND_MARK;
		else if (roll < 96)
			r.kind = KIND_DONE;
		else
			r.kind = KIND_W'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
		if (r.kind == KIND_REMOVE || r.kind == KIND_QUERY) begin
			pick = $urandom_range(0, 9);
			if (pick < 7 && held_total > 0) begin
				r.index      = held_list[$urandom_range(0, held_total - 1)];
				r.generation = gen_of[r.index][GEN_W-1:0];
				if ($urandom_range(0, 9) == 0)
					r.generation = r.generation + 1'b1;
				if (r.check && $urandom_range(0, 9) != 0)
					r.tag = tag_reg;
			end else if (pick < 8 && created != '0) begin
				r.index      = IDX_W'($urandom_range(0, created - 1));
				r.generation = gen_of[r.index][GEN_W-1:0];
			end
			// never remove a slot that already sits on the free list
			if (r.kind == KIND_REMOVE && !held[r.index] && handle_is_live(r))
				r.generation = r.generation ^ GEN_W'(1);
		end
		return r;
	endfunction

	task automatic test_handle_basics();
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b1;
		send_op(make_op(KIND_QUERY, '0, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_ADD, '0, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_ADD, 32'hFFFF_FFFF, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_ADD, 32'h0000_0001, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_QUERY, '0, 10'd0, 12'd1, 16'h0001, 1'b1));
		send_op(make_op(KIND_QUERY, '0, 10'd0, 12'd1, 16'hFFFF, 1'b1));
		send_op(make_op(KIND_QUERY, '0, 10'd0, 12'd0, '0, 1'b0));
		send_op(make_op(KIND_QUERY, '0, 10'd1, 12'hFFF, '0, 1'b0));
		send_op(make_op(KIND_QUERY, '0, 10'h3FF, 12'd1, '0, 1'b0));
		send_op(make_op(KIND_MARK, '0, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_DONE, '0, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_MARK, '0, '0, '0, '0, 1'b0));
		for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
			send_op(make_op(KIND_W'(k), 32'hFFFF_FFFF, 10'h3FF, 12'hFFF, 16'hFFFF, 1'b1));
		send_op(make_op(KIND_REMOVE, '0, 10'd1, 12'd1, 16'h0001, 1'b1));
		send_op(make_op(KIND_REMOVE, '0, 10'd1, 12'd1, 16'h0000, 1'b1));
		send_op(make_op(KIND_QUERY, '0, 10'd1, 12'd2, '0, 1'b0));
		send_op(make_op(KIND_ADD, 32'h8000_0000, '0, '0, '0, 1'b0));
		send_op(make_op(KIND_REMOVE, '0, 10'd1, 12'd2, '0, 1'b0));
		send_op(make_op(KIND_REMOVE, '0, 10'd0, 12'd1, 16'hFFFF, 1'b1));
		send_op(make_op(KIND_REMOVE, '0, 10'd0, 12'd1, '0, 1'b0));
		// free list now holds slot 1 then slot 0: reuse must follow that order
		send_op(make_op(KIND_ADD, nonzero_node(), '0, '0, '0, 1'b0));
		send_op(make_op(KIND_ADD, nonzero_node(), '0, '0, '0, 1'b0));
		send_op(make_op(KIND_DONE, '0, '0, '0, '0, 1'b0));
	endtask

	task automatic test_random_traffic();
		logic [TAG_W-1:0] next_tag;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       next_tag = 16'hFFFF;
				1:       next_tag = 16'h0000;
				default: next_tag = TAG_W'($urandom());
			endcase
			write_owner_tag(next_tag);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % BURST_ITEMS == 0) begin
					sender_gaps     = ($urandom_range(0, 3) != 0);
					receiver_stalls = ($urandom_range(0, 3) != 0);
				end
				// hold off mid-phase until every result is back
				if (phase == 1 && i == PHASE_ITEMS / 2)
					drain_results();
				send_op(random_op());
			end
		end
	endtask

	function automatic void check_field(string name, logic [NODE_W-1:0] want,
			logic [NODE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	task automatic compare_outcome(input outcome_t want, input logic [M_DATA_W-1:0] beat);
		check_field("status", NODE_W'(want.status), NODE_W'(beat[1:0]));
		check_field("handle_valid", NODE_W'(want.valid), NODE_W'(beat[2]));
		check_field("out_index", NODE_W'(want.index), NODE_W'(beat[12:3]));
		check_field("out_generation", NODE_W'(want.generation), NODE_W'(beat[24:13]));
		check_field("out_tag", NODE_W'(want.tag), NODE_W'(beat[40:25]));
		check_field("out_node", want.node, beat[72:41]);
		check_field("used_slots", NODE_W'(want.used), NODE_W'(beat[83:73]));
		check_field("slots_allocated", NODE_W'(want.allocated), NODE_W'(beat[94:84]));
		check_field("needs_update", NODE_W'(want.dirty_layout), NODE_W'(beat[95]));
		check_field("needs_assignment_update", NODE_W'(want.dirty_assign),
			NODE_W'(beat[96]));
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				$error("result beat with nothing outstanding: %h", m_tdata);
				errors++;
			end else begin
				compare_outcome(pending_outcomes.pop_front(), m_tdata);
			end
		end
	end

	// result side back-pressure
	initial begin
		m_tready   = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
				m_tready  <= 1'b0;
				stall_left = pick_gap();
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("generational_handle_allocator verification failed");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_wdata       = '0;
		s_tvalid        = 1'b0;
		s_tdata         = '0;
		s_tuser         = '0;
		sender_gaps     = 1'b0;
		receiver_stalls = 1'b0;
		fl_head         = '0;
		fl_tail         = '0;
		fl_empty        = 1'b1;
		created         = '0;
		busy            = '0;
		dirty           = '0;
		tag_reg         = TAG_W'(1);
		held_total      = 0;
		for (int i = 0; i < CAPACITY; i++)
			held[i] = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_handle_basics();
		test_random_traffic();

		drain_results();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("generational_handle_allocator verification clean");
		else
			$display("generational_handle_allocator verification failed");
		$finish;
	end

endmodule
